/* rtl/core/irtfr_pkg.sv */
package irtfr_pkg;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam int unsigned OUT_WORD_W = 8;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_PREAMBLE = 2'd1,
        PH_DATA     = 2'd2,
        PH_EPILOGUE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_RISE = 2'd1,
        FN_FALL = 2'd2
    } t_func;

    // Sub-step codes inside the preamble.
    localparam logic [1:0] PRE_HIGH1 = 2'd0;
    localparam logic [1:0] PRE_GAP1  = 2'd1;
    localparam logic [1:0] PRE_HIGH2 = 2'd2;
    localparam logic [1:0] PRE_FINAL = 2'd3;

    // Sub-step codes inside the epilogue.
    localparam logic [1:0] EPI_TICK = 2'd0;
    localparam logic [1:0] EPI_GAP  = 2'd1;
    localparam logic [1:0] EPI_HIGH = 2'd2;

    // Word select codes.
    localparam logic [1:0] WS_ID     = 2'd0;
    localparam logic [1:0] WS_ANGLE  = 2'd1;
    localparam logic [1:0] WS_REV    = 2'd2;
    localparam logic [1:0] WS_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        CFG_INTERFRAME_MIN  = 3'd0,
        CFG_PRE_BIT_LEN     = 3'd1,
        CFG_PRE_BIT_TOL     = 3'd2,
        CFG_PRE_DELAY_LEN   = 3'd3,
        CFG_PRE_DELAY_TOL   = 3'd4,
        CFG_BIT_PERIOD      = 3'd5,
        CFG_HALF_BIT_PERIOD = 3'd6,
        CFG_PREAMBLE_TOTAL  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] interframe_min;
        logic [15:0] pre_bit_len;
        logic [15:0] pre_bit_tol;
        logic [15:0] pre_delay_len;
        logic [15:0] pre_delay_tol;
        logic [15:0] bit_period;
        logic [15:0] half_bit_period;
        logic [15:0] preamble_total;
    } t_cfg;

    typedef struct packed {
        logic                  timer_restart;
        logic                  period_load;
        logic [15:0]           new_period;
        logic                  frame_valid;
        logic                  frame_bad;
        logic [OUT_WORD_W-1:0] beamer_id;
        logic [OUT_WORD_W-1:0] angle_code;
    } t_result;

endpackage

/* rtl/core/irtfr_window.sv */
module irtfr_window (
    input  logic [15:0] i_x,
    input  logic [15:0] i_len,
    input  logic [15:0] i_tol,
    output logic        o_hit
);
    logic [16:0] len_plus_tol;
    logic [16:0] x_plus_tol;

    // Both sums are one bit wider so the window edges never wrap.
    assign len_plus_tol = {1'b0, i_len} + {1'b0, i_tol};
    assign x_plus_tol   = {1'b0, i_x} + {1'b0, i_tol};
    assign o_hit = ({1'b0, i_x} < len_plus_tol) && (x_plus_tol > {1'b0, i_len});
endmodule

/* rtl/core/irtfr_ctrl.sv */
module irtfr_ctrl #(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  irtfr_pkg::t_cfg   i_cfg,
    input  logic [1:0]        i_func,
    input  logic              i_line_level,
    input  logic [15:0]       i_low_duration,
    input  logic [15:0]       i_high_duration,
    output irtfr_pkg::t_result o_result
);
    import irtfr_pkg::*;

    localparam int unsigned BP_W = $clog2(WORD_BITS + 1);
    localparam logic [BP_W-1:0] BP_LAST = BP_W'(WORD_BITS);

    t_phase                r_phase, n_phase;
    logic [1:0]            r_sub, n_sub;
    logic [1:0]            r_ws, n_ws;
    logic [BP_W-1:0]       r_bp, n_bp;
    logic [WORD_BITS-1:0]  r_id, n_id;
    logic [WORD_BITS-1:0]  r_ang, n_ang;
    logic [WORD_BITS-1:0]  r_rev, n_rev;

    logic                  good_bit;
    logic                  good_gap;
    logic                  tick, rise, fall;
    logic                  abort;
    logic [WORD_BITS-1:0]  bit_set;
    logic [BP_W-1:0]       bp_inc;
    logic [BP_W-1:0]       bp_after;
    logic                  angle_ok;
    t_result               res;

    irtfr_window u_bit_win (
        .i_x   (i_high_duration),
        .i_len (i_cfg.pre_bit_len),
        .i_tol (i_cfg.pre_bit_tol),
        .o_hit (good_bit)
    );

    irtfr_window u_gap_win (
        .i_x   (i_low_duration),
        .i_len (i_cfg.pre_delay_len),
        .i_tol (i_cfg.pre_delay_tol),
        .o_hit (good_gap)
    );

    assign tick = (i_func == FN_TICK);
    assign rise = (i_func == FN_RISE);
    assign fall = (i_func == FN_FALL);

    // Words arrive MSB first: bit position zero lands in the top bit.
    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            bit_set[k] = i_line_level && (r_bp == BP_W'(WORD_BITS - 1 - k));
        end
    end

    assign bp_inc   = r_bp + BP_W'(1);
    assign bp_after = (r_bp < BP_LAST) ? bp_inc : r_bp;
    assign angle_ok = (r_ang == ~r_rev);

    always_comb begin
        n_phase = r_phase;
        n_sub   = r_sub;
        n_ws    = r_ws;
        n_bp    = r_bp;
        n_id    = r_id;
        n_ang   = r_ang;
        n_rev   = r_rev;
        res     = '0;
        abort   = 1'b0;

        case (r_phase)
            PH_WAIT: begin
                if (rise && (i_low_duration > i_cfg.interframe_min)) begin
                    res.timer_restart = 1'b1;
                    res.period_load   = 1'b1;
                    res.new_period    = i_cfg.preamble_total;
                    n_phase           = PH_PREAMBLE;
                    n_sub             = PRE_HIGH1;
                end
            end
            PH_PREAMBLE: begin
                case (r_sub)
                    PRE_HIGH1: begin
                        if (fall && good_bit) begin
                            n_sub = PRE_GAP1;
                        end else begin
                            abort = 1'b1;
                        end
                    end
                    PRE_GAP1: begin
                        if (rise && good_gap) begin
                            n_sub = PRE_HIGH2;
                        end else begin
                            abort = 1'b1;
                        end
                    end
                    PRE_HIGH2: begin
                        if (fall && good_bit) begin
                            res.timer_restart = 1'b1;
                            res.period_load   = 1'b1;
                            res.new_period    = i_cfg.pre_delay_len;
                            n_sub             = PRE_FINAL;
                        end else begin
                            abort = 1'b1;
                        end
                    end
                    default: begin
                        if (tick) begin
                            res.period_load = 1'b1;
                            res.new_period  = i_cfg.half_bit_period;
                            n_sub           = PRE_HIGH1;
                            n_phase         = PH_DATA;
                            n_ws            = WS_ID;
                            n_id            = '0;
                            n_ang           = '0;
                            n_rev           = '0;
                            n_bp            = '0;
                        end
                    end
                endcase
            end
            PH_DATA: begin
                if (tick) begin
                    case (r_ws)
                        WS_ID, WS_ANGLE: begin
                            if ((r_ws == WS_ID) && (r_bp == '0)) begin
                                res.period_load = 1'b1;
                                res.new_period  = i_cfg.bit_period;
                            end
                            if (r_bp < BP_LAST) begin
                                if (r_ws == WS_ID) begin
                                    n_id = r_id | bit_set;
                                end else begin
                                    n_ang = r_ang | bit_set;
                                end
                                n_bp = bp_inc;
                            end else begin
                                // This tick is the gap between two words.
                                n_ws = r_ws + 2'd1;
                                n_bp = '0;
                            end
                        end
                        WS_REV: begin
                            n_rev = r_rev | bit_set;
                            n_bp  = bp_after;
                            if (bp_after >= BP_LAST) begin
                                n_bp            = '0;
                                res.period_load = 1'b1;
                                res.new_period  = i_cfg.half_bit_period;
                                n_phase         = PH_EPILOGUE;
                                n_sub           = EPI_TICK;
                            end
                        end
                        default: begin
                            abort = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                case (r_sub)
                    EPI_TICK: begin
                        if (tick) begin
                            res.timer_restart = 1'b1;
                            res.period_load   = 1'b1;
                            res.new_period    = TIMER_MAX;
                            n_sub             = EPI_GAP;
                        end
                    end
                    EPI_GAP: begin
                        if (rise && good_gap) begin
                            n_sub = EPI_HIGH;
                        end
                    end
                    EPI_HIGH: begin
                        if (fall && good_bit) begin
                            res.frame_valid = angle_ok;
                            res.frame_bad   = !angle_ok;
                            res.beamer_id   = OUT_WORD_W'(r_id);
                            res.angle_code  = OUT_WORD_W'(r_ang);
                        end
                        abort = 1'b1;
                    end
                    default: begin
                        abort = 1'b1;
                    end
                endcase
            end
        endcase

        if (abort) begin
            n_phase           = PH_WAIT;
            n_ws              = WS_ID;
            res.timer_restart = 1'b1;
            res.period_load   = 1'b1;
            res.new_period    = TIMER_MAX;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_sub   <= PRE_HIGH1;
            r_ws    <= WS_ID;
            r_bp    <= '0;
            r_id    <= '0;
            r_ang   <= '0;
            r_rev   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_ws    <= n_ws;
            r_bp    <= n_bp;
            r_id    <= n_id;
            r_ang   <= n_ang;
            r_rev   <= n_rev;
        end
    end

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.frame_valid && res.frame_bad))
        else $error("frame reported both valid and bad");

    a_frame_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.frame_valid || res.frame_bad) |->
            (res.timer_restart && res.period_load && n_phase == PH_WAIT))
        else $error("frame report without receiver reset");

    a_period_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res.period_load |-> (res.new_period == '0))
        else $error("period driven without load");

    a_ws_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_ws != WS_UNUSED))
        else $error("unused word select reached in data phase");

    a_bp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bp <= BP_LAST))
        else $error("bit position beyond word length");
endmodule

/* rtl/core/ir_timed_frame_receiver_core.sv */
// A result is registered and presented in the cycle after its input transfer.
// Throughput: one event per cycle unless the output stalls; the decoder state
// updates in a single pass and a result register separates the input and output
// handshakes. A new event is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) clears all configuration to zero, returns the
// receiver to waiting for a start, and empties the result register.
module ir_timed_frame_receiver_core #(
    parameter int unsigned WORD_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic        i_line_level,
    input  logic [15:0] i_low_duration,
    input  logic [15:0] i_high_duration,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_timer_restart,
    output logic        o_period_load,
    output logic [15:0] o_new_period,
    output logic        o_frame_valid,
    output logic        o_frame_bad,
    output logic [7:0]  o_beamer_id,
    output logic [7:0]  o_angle_code
);
    import irtfr_pkg::*;

    t_cfg    r_cfg;
    t_result r_res;
    t_result res;
    logic    r_out_valid;
    logic    in_xfer;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INTERFRAME_MIN:  r_cfg.interframe_min  <= i_cfg_wdata;
                CFG_PRE_BIT_LEN:     r_cfg.pre_bit_len     <= i_cfg_wdata;
                CFG_PRE_BIT_TOL:     r_cfg.pre_bit_tol     <= i_cfg_wdata;
                CFG_PRE_DELAY_LEN:   r_cfg.pre_delay_len   <= i_cfg_wdata;
                CFG_PRE_DELAY_TOL:   r_cfg.pre_delay_tol   <= i_cfg_wdata;
                CFG_BIT_PERIOD:      r_cfg.bit_period      <= i_cfg_wdata;
                CFG_HALF_BIT_PERIOD: r_cfg.half_bit_period <= i_cfg_wdata;
                CFG_PREAMBLE_TOTAL:  r_cfg.preamble_total  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    irtfr_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (in_xfer),
        .i_cfg           (r_cfg),
        .i_func          (i_func),
        .i_line_level    (i_line_level),
        .i_low_duration  (i_low_duration),
        .i_high_duration (i_high_duration),
        .o_result        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_timer_restart = r_res.timer_restart;
    assign o_period_load   = r_res.period_load;
    assign o_new_period    = r_res.new_period;
    assign o_frame_valid   = r_res.frame_valid;
    assign o_frame_bad     = r_res.frame_bad;
    assign o_beamer_id     = r_res.beamer_id;
    assign o_angle_code    = r_res.angle_code;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while a result is stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("transfer did not produce a result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !in_xfer) |=> !r_out_valid)
        else $error("drained result still shown");
endmodule
